// File: hw/rtl/dcg_pkg.sv
// types, constants and codes shared by the disk command geometry checker
`default_nettype none

package dcg_pkg;

  localparam int unsigned AddrW    = 21;
  localparam int unsigned GeomW    = 9;
  localparam int unsigned CylW     = 16;
  localparam int unsigned HeadW    = 8;
  localparam int unsigned SizeW    = 3;
  localparam int unsigned LenW     = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = CylW + GeomW;

  localparam logic [7:0] OpRequestSense = 8'h03;
  localparam logic [7:0] OpFormatTrack  = 8'h06;
  localparam logic [7:0] OpRead6        = 8'h08;
  localparam logic [7:0] OpAssignParam  = 8'hc2;
  localparam logic [7:0] OpReadBuffer   = 8'hec;

  localparam logic [2:0] ActStatus  = 3'd0;
  localparam logic [2:0] ActDataIn  = 3'd1;
  localparam logic [2:0] ActDataOut = 3'd2;
  localparam logic [2:0] ActForward = 3'd3;
  localparam logic [2:0] ActFormat  = 3'd4;
  localparam logic [2:0] ActStored  = 3'd5;

  localparam logic [1:0] SenseNone     = 2'd0;
  localparam logic [1:0] SenseNotReady = 2'd1;
  localparam logic [1:0] SenseSeekFail = 2'd2;

  localparam logic [CfgIdxW-1:0] RegPresentMask = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDisk0Heads  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDisk0Cyls   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDisk0Size   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDisk1Heads  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDisk1Cyls   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDisk1Size   = 3'd6;

  localparam logic [SizeW-1:0] Size128  = 3'd0;
  localparam logic [SizeW-1:0] Size256  = 3'd1;
  localparam logic [SizeW-1:0] Size512  = 3'd2;
  localparam logic [SizeW-1:0] Size1024 = 3'd3;

  localparam logic [GeomW-1:0] Secs128  = 9'd53;
  localparam logic [GeomW-1:0] Secs256  = 9'd32;
  localparam logic [GeomW-1:0] Secs512  = 9'd18;
  localparam logic [GeomW-1:0] Secs1024 = 9'd9;

  localparam logic [LenW-1:0] LenBuffer = 10'd512;
  localparam logic [LenW-1:0] LenParams = 10'd10;

  typedef struct packed {
    logic             func;
    logic [7:0]       opcode;
    logic             drive_sel;
    logic [AddrW-1:0] block_address;
    logic [7:0]       head_count_less_one;
    logic [15:0]      cylinder_count_less_one;
    logic [7:0]       sector_count_less_one;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       action;
    logic             check_condition;
    logic [1:0]       sense_code;
    logic [LenW-1:0]  transfer_length;
    logic [AddrW-1:0] track_number;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/dcg_stream_if.sv
// valid/ready channel carrying one payload
`default_nettype none

interface dcg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dcg_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module dcg_div #(
  parameter int unsigned DividendW = dcg_pkg::AddrW,
  parameter int unsigned DivisorW  = dcg_pkg::GeomW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic      [DividendW-1:0] quotient_o,
  output logic      [DivisorW-1:0]  remainder_o,
  output logic                      done_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  div_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 fits;

  always_comb begin
    trial = {rem_q, quo_q[DividendW-1]};
    diff  = trial - {1'b0, div_q};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    quo_d = {quo_q[DividendW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DividendW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

// File: hw/rtl/disk_command_geometry_checker_core.sv
// disk command front end with per-drive geometry and track range check
//
//   channel  dir  payload  handshake
//   cmd_i    in   cmd_t    valid/ready
//   res_o    out  res_t    valid/ready
//   cfg_i    in   cfg_t    valid/ready, always ready
//
// read-6 and format-track on a present drive reach their result through two
// 21-step passes of the shared serial divider (track, then track modulo heads)
// all other commands and parameter blocks that close an assignment go straight
// to the final state; a parameter block with no assignment open is dropped
// reset clears geometry (sector size to 512), pending assignment, output valid
// a stalled result holds the block in its final state until taken
`default_nettype none

module disk_command_geometry_checker_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dcg_stream_if.sink   cmd_i,
  dcg_stream_if.sink   cfg_i,
  dcg_stream_if.source res_o
);
  import dcg_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv1 = 2'd1;
  localparam logic [1:0] StDiv2 = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [1:0]       present_q;
  logic [HeadW-1:0] heads_q [2];
  logic [CylW-1:0]  cyls_q [2];
  logic [SizeW-1:0] size_q [2];
  logic [GeomW-1:0] lheads_q [2];
  logic [GeomW-1:0] lsecs_q [2];
  logic             pend_q;
  logic             pdrive_q;

  logic             drive_q;
  logic             fmt_q;
  logic [AddrW-1:0] track_q;
  logic [GeomW-1:0] hdiv_q;
  logic [ProdW-1:0] prod_q;
  res_t             res_q, res_d;
  res_t             out_q;
  logic             out_valid_q;

  cmd_t             cmd;
  logic             cmd_acc;
  logic             cfg_acc;
  logic             out_free;
  logic             present;
  logic [GeomW-1:0] secs_eff;
  logic [GeomW-1:0] heads_eff;
  logic [GeomW-1:0] new_secs;
  logic             div_start;
  logic [AddrW-1:0] div_dividend;
  logic [GeomW-1:0] div_divisor;
  logic [AddrW-1:0] div_quo;
  logic [GeomW-1:0] div_rem;
  logic             div_done;
  logic             range_ok;

  assign cmd      = cmd_i.payload;
  assign cmd_acc  = cmd_i.valid & cmd_i.ready;
  assign cfg_acc  = cfg_i.valid & cfg_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign cmd_i.ready   = (state_q == StIdle);
  assign cfg_i.ready   = 1'b1;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  assign present   = present_q[cmd.drive_sel];
  assign secs_eff  = (lsecs_q[cmd.drive_sel] == '0) ? GeomW'(1) : lsecs_q[cmd.drive_sel];
  assign heads_eff = (lheads_q[cmd.drive_sel] == '0) ? GeomW'(1) : lheads_q[cmd.drive_sel];

  always_comb begin
    new_secs = GeomW'(cmd.sector_count_less_one) + GeomW'(1);
    if (cmd.sector_count_less_one == '0) begin
      if (present_q[pdrive_q]) begin
        case (size_q[pdrive_q])
          Size128:  new_secs = Secs128;
          Size256:  new_secs = Secs256;
          Size512:  new_secs = Secs512;
          Size1024: new_secs = Secs1024;
          default:  new_secs = lsecs_q[pdrive_q];
        endcase
      end
    end
  end

  dcg_div #(
    .DividendW(AddrW),
    .DivisorW (GeomW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .done_o     (div_done)
  );

  assign range_ok = ({1'b0, heads_q[drive_q]} >= div_rem) &&
                    (ProdW'(track_q) < prod_q);

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = cmd.block_address;
    div_divisor  = secs_eff;
    case (state_q)
      StIdle: begin
        if (cmd_acc) begin
          res_d        = '0;
          res_d.action = ActForward;
          if (cmd.func) begin
            if (pend_q) begin
              res_d.action = ActStored;
              state_d      = StFin;
            end
          end else begin
            state_d = StFin;
            if (!present) begin
              if (cmd.opcode != OpRequestSense) begin
                res_d.action          = ActStatus;
                res_d.check_condition = 1'b1;
                res_d.sense_code      = SenseNotReady;
              end
            end else begin
              case (cmd.opcode)
                OpReadBuffer: begin
                  res_d.action          = ActDataIn;
                  res_d.transfer_length = LenBuffer;
                end
                OpAssignParam: begin
                  res_d.action          = ActDataOut;
                  res_d.transfer_length = LenParams;
                end
                OpRead6, OpFormatTrack: begin
                  div_start = 1'b1;
                  state_d   = StDiv1;
                end
                default: res_d.action = ActForward;
              endcase
            end
          end
        end
      end
      StDiv1: begin
        div_dividend = div_quo;
        div_divisor  = hdiv_q;
        if (div_done) begin
          div_start = 1'b1;
          state_d   = StDiv2;
        end
      end
      StDiv2: begin
        if (div_done) begin
          res_d.track_number    = track_q;
          res_d.transfer_length = '0;
          if (range_ok) begin
            res_d.action          = fmt_q ? ActFormat : ActForward;
            res_d.check_condition = 1'b0;
            res_d.sense_code      = SenseNone;
          end else begin
            res_d.action          = ActStatus;
            res_d.check_condition = 1'b1;
            res_d.sense_code      = SenseSeekFail;
          end
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      present_q   <= '0;
      heads_q     <= '{default: '0};
      cyls_q      <= '{default: '0};
      size_q      <= '{default: Size512};
      lheads_q    <= '{default: '0};
      lsecs_q     <= '{default: '0};
      pend_q      <= 1'b0;
      pdrive_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        case (cfg_i.payload.index)
          RegPresentMask: present_q  <= cfg_i.payload.data[1:0];
          RegDisk0Heads:  heads_q[0] <= cfg_i.payload.data[HeadW-1:0];
          RegDisk0Cyls:   cyls_q[0]  <= cfg_i.payload.data[CylW-1:0];
          RegDisk0Size:   size_q[0]  <= cfg_i.payload.data[SizeW-1:0];
          RegDisk1Heads:  heads_q[1] <= cfg_i.payload.data[HeadW-1:0];
          RegDisk1Cyls:   cyls_q[1]  <= cfg_i.payload.data[CylW-1:0];
          RegDisk1Size:   size_q[1]  <= cfg_i.payload.data[SizeW-1:0];
          default: ;
        endcase
      end
      if (cmd_acc) begin
        if (cmd.func) begin
          if (pend_q) begin
            pend_q             <= 1'b0;
            lheads_q[pdrive_q] <= GeomW'(cmd.head_count_less_one) + GeomW'(1);
            lsecs_q[pdrive_q]  <= new_secs;
          end
        end else begin
          pend_q <= present && (cmd.opcode == OpAssignParam);
          if (present && (cmd.opcode == OpAssignParam)) begin
            pdrive_q <= cmd.drive_sel;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == StFin && out_free) begin
      out_q <= res_q;
    end
    if (state_q == StIdle && cmd_acc) begin
      drive_q <= cmd.drive_sel;
      fmt_q   <= (cmd.opcode == OpFormatTrack);
      hdiv_q  <= heads_eff;
      prod_q  <= ProdW'(cyls_q[cmd.drive_sel]) * ProdW'(heads_eff);
    end
    if (state_q == StDiv1 && div_done) begin
      track_q <= div_quo;
    end
  end

  a_div_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv1 || state_q == StDiv2))
    else $error("divider finished outside a divide state");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_free) |=> out_valid_q)
    else $error("result not loaded on leaving final state");

  a_seek_fail_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.sense_code == SenseSeekFail) |->
      (out_q.check_condition && out_q.action == ActStatus))
    else $error("seek fail without check condition status");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv1 || state_q == StDiv2) |-> !cmd_acc)
    else $error("request accepted while dividing");

endmodule

`default_nettype wire
